@@ sv/tbdmc_pkg.sv @@
package tbdmc_pkg;

  localparam int unsigned SumW    = 32;
  localparam int unsigned AccW    = 64;
  localparam int unsigned MassW   = 24;
  localparam int unsigned KindW   = 2;
  localparam int unsigned CfgIdxW = 8;

  // particle kind codes
  localparam logic [KindW-1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [KindW-1:0] KIND_KAON    = 2'd1;
  localparam logic [KindW-1:0] KIND_LAMBDA  = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_PION_MASS   = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_PROTON_MASS = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_KAON_REF    = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_LAMBDA_REF  = 8'd3;

  localparam logic [MassW-1:0] PION_MASS_RST   = 24'd572;
  localparam logic [MassW-1:0] PROTON_MASS_RST = 24'd3843;
  localparam logic [MassW-1:0] KAON_REF_RST    = 24'd2038;
  localparam logic [MassW-1:0] LAMBDA_REF_RST  = 24'd4570;

  localparam logic signed [33:0] SAT_MAX = 34'sd2147483647;
  localparam logic signed [33:0] SAT_MIN = -34'sd2147483648;

  function automatic logic [31:0] abs32(input logic signed [31:0] x);
    abs32 = x[31] ? 32'(-x) : 32'(x);
  endfunction

  // saturating add into a signed 32-bit sum
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [33:0] b);
    logic signed [33:0] s;
    s = 34'(a) + b;
    if (s > SAT_MAX) sat_add = 32'sh7FFFFFFF;
    else if (s < SAT_MIN) sat_add = 32'sh80000000;
    else sat_add = s[31:0];
  endfunction

endpackage

@@ sv/two_body_decay_mass_classifier.sv @@
// Two-body decay classifier: tracks of one event arrive one beat each on the
// slave stream (tdata = px, py, pz; tuser = charge; tlast = last track). Each
// track adds to saturating momentum sums and to two energy sums, kaon
// hypothesis (pion mass everywhere) and lambda hypothesis (proton mass for
// positive, pion mass for negative tracks); E = floor sqrt(p^2 + m^2). On the
// last track, an event with exactly one positive and one negative track yields
// both invariant masses floor sqrt(E^2 - P^2) (zero when negative) and reports
// the hypothesis closer to its reference mass, ties to lambda; any other
// charge mix reports kind unknown with energy and mass of -1.0. Every product
// goes through one shared 32x32 squarer and every root through one shared
// two-bit-per-cycle root unit of 32 steps. A last track of a valid event also
// runs the two mass roots before the result hand-off. The slave side is not
// ready while an item is in work. The result sits in an output register, so
// the next event can start while it waits.
// Mass registers are written through the cfg channel, which is always ready.
module two_body_decay_mass_classifier
  import tbdmc_pkg::*;
#(
  parameter int unsigned MOMENTUM_BITS = 24,
  parameter int unsigned FRACTION_BITS = 12
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  // momentum_x, momentum_y, momentum_z, zero pad
  input  logic [((3*MOMENTUM_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // track_charge
  input  logic [1:0]                                s_axis_tuser,
  input  logic                                      s_axis_tlast,
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  // total_energy, invariant_mass
  output logic [63:0]                               m_axis_tdata,
  // particle_kind
  output logic [KindW-1:0]                          m_axis_tuser,
  input  logic                                      cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  logic [CfgIdxW-1:0]                        cfg_index_i,
  input  logic [MassW-1:0]                          cfg_data_i
);

  localparam logic signed [31:0] UNKNOWN_VAL = -(32'sd1 <<< FRACTION_BITS);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ACC, S_DIFF, S_ROOT, S_POST, S_EMIT
  } state_e;

  // micro-op: which operand the squarer and accumulator handle
  typedef enum logic [3:0] {
    OP_PX, OP_PY, OP_PZ, OP_MPI, OP_MPR,
    OP_SX, OP_SY, OP_SZ, OP_EK, OP_EL
  } op_e;

  state_e state_q, state_d;
  op_e    op_q, op_d;

  logic [MassW-1:0] pion_q, proton_q, kref_q, lref_q;

  logic signed [MOMENTUM_BITS-1:0] px_q, py_q, pz_q;
  logic signed [1:0]               q_q;
  logic                            last_q;

  logic signed [31:0] sx_q, sy_q, sz_q, ek_q, el_q;
  logic signed [31:0] sx_d, sy_d, sz_d, ek_d, el_d;
  logic [1:0]         pos_q, neg_q, pos_d, neg_d;

  logic [31:0]     mul_a;
  logic [AccW-1:0] prod_q, prod_d;
  logic [AccW-1:0] acc_q, acc_d, p2_q, p2_d;
  logic [AccW-1:0] res_q, res_d, bit_q, bit_d;
  logic [AccW-1:0] base, trial;
  logic [31:0]     root, mk_q, mk_d, ml_q, ml_d;

  logic            m_valid_q, m_valid_d;
  logic [63:0]     m_data_q, m_data_d;
  logic [KindW-1:0] m_user_q, m_user_d;

  logic             accept, emit;
  logic signed [33:0] dk, dl;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // squarer operand
  always_comb begin
    case (op_q)
      OP_PX:   mul_a = abs32(32'(px_q));
      OP_PY:   mul_a = abs32(32'(py_q));
      OP_PZ:   mul_a = abs32(32'(pz_q));
      OP_MPI:  mul_a = 32'(pion_q);
      OP_MPR:  mul_a = 32'(proton_q);
      OP_SX:   mul_a = abs32(sx_q);
      OP_SY:   mul_a = abs32(sy_q);
      OP_SZ:   mul_a = abs32(sz_q);
      OP_EK:   mul_a = abs32(ek_q);
      OP_EL:   mul_a = abs32(el_q);
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    case (op_q)
      OP_PY, OP_PZ, OP_SY, OP_SZ: base = acc_q;
      OP_MPI, OP_MPR:             base = p2_q;
      default:                    base = '0;
    endcase
  end

  assign trial = res_q + bit_q;
  assign root  = res_q[31] ? 32'h7FFFFFFF : res_q[31:0];
  assign dk    = $signed({2'b0, mk_q}) - $signed({10'b0, kref_q});
  assign dl    = $signed({2'b0, ml_q}) - $signed({10'b0, lref_q});

  always_comb begin
    logic [33:0] adk, adl;
    adk = dk[33] ? 34'(-dk) : 34'(dk);
    adl = dl[33] ? 34'(-dl) : 34'(dl);

    state_d   = state_q;
    op_d      = op_q;
    sx_d      = sx_q;
    sy_d      = sy_q;
    sz_d      = sz_q;
    ek_d      = ek_q;
    el_d      = el_q;
    pos_d     = pos_q;
    neg_d     = neg_q;
    prod_d    = prod_q;
    acc_d     = acc_q;
    p2_d      = p2_q;
    res_d     = res_q;
    bit_d     = bit_q;
    mk_d      = mk_q;
    ml_d      = ml_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    emit      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          sx_d = sat_add(sx_q, 34'($signed(s_axis_tdata[MOMENTUM_BITS-1:0])));
          sy_d = sat_add(sy_q,
                   34'($signed(s_axis_tdata[2*MOMENTUM_BITS-1:MOMENTUM_BITS])));
          sz_d = sat_add(sz_q,
                   34'($signed(s_axis_tdata[3*MOMENTUM_BITS-1:2*MOMENTUM_BITS])));
          if (s_axis_tuser == 2'b01 && pos_q != 2'd2) pos_d = pos_q + 2'd1;
          if (s_axis_tuser == 2'b11 && neg_q != 2'd2) neg_d = neg_q + 2'd1;
          op_d    = OP_PX;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d  = AccW'(mul_a) * AccW'(mul_a);
        state_d = S_ACC;
      end
      S_ACC: begin
        acc_d   = base + prod_q;
        state_d = S_MUL;
        case (op_q)
          OP_PX: op_d = OP_PY;
          OP_PY: op_d = OP_PZ;
          OP_PZ: begin
            p2_d = acc_d;
            op_d = OP_MPI;
          end
          OP_SX: op_d = OP_SY;
          OP_SY: op_d = OP_SZ;
          OP_SZ: begin
            p2_d = acc_d;
            op_d = OP_EK;
          end
          OP_MPI, OP_MPR: begin
            res_d   = '0;
            bit_d   = AccW'(1) << (AccW - 2);
            state_d = S_ROOT;
          end
          default: state_d = S_DIFF;
        endcase
      end
      S_DIFF: begin
        acc_d   = (acc_q > p2_q) ? acc_q - p2_q : '0;
        res_d   = '0;
        bit_d   = AccW'(1) << (AccW - 2);
        state_d = S_ROOT;
      end
      S_ROOT: begin
        if (acc_q >= trial) begin
          acc_d = acc_q - trial;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) state_d = S_POST;
      end
      S_POST: begin
        case (op_q)
          OP_MPI: begin
            ek_d = sat_add(ek_q, 34'(root));
            if (q_q == -2'sd1) el_d = sat_add(el_q, 34'(root));
          end
          OP_MPR: el_d = sat_add(el_q, 34'(root));
          OP_EK:  mk_d = root;
          default: ml_d = root;
        endcase
        if (op_q == OP_MPI && q_q == 2'sd1) begin
          op_d    = OP_MPR;
          state_d = S_MUL;
        end else if (op_q == OP_MPI || op_q == OP_MPR) begin
          if (!last_q) state_d = S_IDLE;
          else if (pos_q == 2'd1 && neg_q == 2'd1) begin
            op_d    = OP_SX;
            state_d = S_MUL;
          end else state_d = S_EMIT;
        end else if (op_q == OP_EK) begin
          op_d    = OP_EL;
          state_d = S_MUL;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          emit      = 1'b1;
          m_valid_d = 1'b1;
          if (pos_q != 2'd1 || neg_q != 2'd1) begin
            m_user_d = KIND_UNKNOWN;
            m_data_d = {UNKNOWN_VAL, UNKNOWN_VAL};
          end else if (adk < adl) begin
            m_user_d = KIND_KAON;
            m_data_d = {mk_q, ek_q};
          end else begin
            m_user_d = KIND_LAMBDA;
            m_data_d = {ml_q, el_q};
          end
          sx_d    = '0;
          sy_d    = '0;
          sz_d    = '0;
          ek_d    = '0;
          el_d    = '0;
          pos_d   = '0;
          neg_d   = '0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= OP_PX;
      pion_q    <= PION_MASS_RST;
      proton_q  <= PROTON_MASS_RST;
      kref_q    <= KAON_REF_RST;
      lref_q    <= LAMBDA_REF_RST;
      sx_q      <= '0;
      sy_q      <= '0;
      sz_q      <= '0;
      ek_q      <= '0;
      el_q      <= '0;
      pos_q     <= '0;
      neg_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      sx_q      <= sx_d;
      sy_q      <= sy_d;
      sz_q      <= sz_d;
      ek_q      <= ek_d;
      el_q      <= el_d;
      pos_q     <= pos_d;
      neg_q     <= neg_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_PION_MASS:   pion_q   <= cfg_data_i;
          REG_PROTON_MASS: proton_q <= cfg_data_i;
          REG_KAON_REF:    kref_q   <= cfg_data_i;
          REG_LAMBDA_REF:  lref_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q   <= s_axis_tdata[MOMENTUM_BITS-1:0];
      py_q   <= s_axis_tdata[2*MOMENTUM_BITS-1:MOMENTUM_BITS];
      pz_q   <= s_axis_tdata[3*MOMENTUM_BITS-1:2*MOMENTUM_BITS];
      q_q    <= s_axis_tuser;
      last_q <= s_axis_tlast;
    end
    prod_q   <= prod_d;
    acc_q    <= acc_d;
    p2_q     <= p2_d;
    res_q    <= res_d;
    bit_q    <= bit_d;
    mk_q     <= mk_d;
    ml_q     <= ml_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

`ifndef SYNTHESIS
  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != 2'd3)
    else $error("illegal particle kind");

  a_unknown_vals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_UNKNOWN) |->
      (m_axis_tdata[31:0] == UNKNOWN_VAL && m_axis_tdata[63:32] == UNKNOWN_VAL))
    else $error("unknown result without -1.0 values");

  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q != 2'd3 && neg_q != 2'd3)
    else $error("track counter past saturation");

  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (ek_q == '0 && el_q == '0 && pos_q == '0 && neg_q == '0 && m_axis_tvalid))
    else $error("event state not cleared after result");
`endif

endmodule
